// ===== sv/ctef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctef_pkg
// Types and constants shared by the capture timestamp FIFO modules.
// ----------------------------------------------------------------------------
package ctef_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STAMP_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 10;
  localparam int unsigned DROP_W   = 16;
  localparam int unsigned TBITS_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [VALUE_W-1:0] FULL_MASK = 32'hFFFF_FFFF;
  localparam logic [TBITS_W-1:0] TBITS_MAX = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_CAPTURE   = 3'd0,
    REQ_TICK      = 3'd1,
    REQ_POP       = 3'd2,
    REQ_CLR_UPPER = 3'd3,
    REQ_CLR_DROP  = 3'd4,
    REQ_FLUSH     = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_REFUSED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STORE_EN  = 2'd0,
    CFG_TIMER_BITS = 2'd1
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // an item is accepted this cycle
    logic load_result;  // load the output register
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/ctef_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctef_ctrl
// Controller: sequences one item through accept and result load, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module ctef_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ctef_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // The output register is free when empty or being emptied this cycle.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    cmd.take        = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take  = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd.load_result = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ctef_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctef_datapath
// Datapath: configuration registers, timestamp extension, ring memory with
// its pointers, drop counter and the output register.
// ----------------------------------------------------------------------------
module ctef_datapath #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire ctef_pkg::cmd_t                  cmd,
  input  wire logic                            cfg_we,
  input  wire logic [ctef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ctef_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [ctef_pkg::VALUE_W-1:0]    in_capture_value,
  input  wire logic                            in_wrapped_flag,
  output logic [ctef_pkg::STATUS_W-1:0]        out_status,
  output logic [ctef_pkg::STAMP_W-1:0]         out_read_timestamp,
  output logic [ctef_pkg::COUNT_W-1:0]         out_entry_count,
  output logic [ctef_pkg::DROP_W-1:0]          out_overflow_count
);

  localparam int unsigned DEPTH = 1 << LOG_DEPTH;

  logic [ctef_pkg::STAMP_W-1:0] ring_mem [DEPTH];
  logic [ctef_pkg::STAMP_W-1:0] rd_data_r;

  logic                            store_en_r;
  logic [ctef_pkg::TBITS_W-1:0]    tbits_r;
  logic [LOG_DEPTH-1:0]            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ctef_pkg::STAMP_W-1:0]    upper_r, upper_nxt;
  logic [ctef_pkg::DROP_W-1:0]     drop_r, drop_nxt;
  ctef_pkg::status_t               pend_status_r, pend_status_nxt;
  logic                            pend_pop_r, pend_pop_nxt;

  logic [ctef_pkg::STATUS_W-1:0]   out_status_r;
  logic [ctef_pkg::STAMP_W-1:0]    out_stamp_r;
  logic [ctef_pkg::COUNT_W-1:0]    out_count_r;
  logic [ctef_pkg::DROP_W-1:0]     out_drop_r;

  logic [ctef_pkg::VALUE_W-1:0]    mask;
  logic [ctef_pkg::STAMP_W-1:0]    period;
  logic [ctef_pkg::STAMP_W-1:0]    base_stamp;
  logic [ctef_pkg::STAMP_W-1:0]    ext_stamp;
  logic                            wrap_hit;
  logic [LOG_DEPTH-1:0]            held;
  logic                            mem_we;
  logic                            mem_re;

  // A timer width of 32 or more gives the full 32-bit mask.
  always_comb begin
    if (tbits_r >= ctef_pkg::TBITS_MAX) begin
      mask = ctef_pkg::FULL_MASK;
    end else begin
      mask = (32'd1 << tbits_r[4:0]) - 32'd1;
    end
  end

  assign period     = 64'(mask) + 64'd1;
  assign base_stamp = upper_r | 64'(in_capture_value & mask);
  // The wrap test uses the raw value, not the masked one.
  assign wrap_hit   = in_wrapped_flag && (in_capture_value < (mask >> 1));
  assign ext_stamp  = wrap_hit ? (base_stamp + period) : base_stamp;
  assign held       = wp_r - rp_r;

  always_comb begin
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    upper_nxt       = upper_r;
    drop_nxt        = drop_r;
    pend_status_nxt = pend_status_r;
    pend_pop_nxt    = pend_pop_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    if (cmd.take) begin
      pend_status_nxt = ctef_pkg::STAT_OK;
      pend_pop_nxt    = 1'b0;
      unique case (ctef_pkg::req_t'(in_req_type))
        ctef_pkg::REQ_CAPTURE: begin
          if (!store_en_r) begin
            pend_status_nxt = ctef_pkg::STAT_REFUSED;
          end else if (held != '1) begin
            mem_we = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end else begin
            pend_status_nxt = ctef_pkg::STAT_FULL;
            if (drop_r != '1) begin
              drop_nxt = drop_r + 1'b1;
            end
          end
        end
        ctef_pkg::REQ_TICK: begin
          upper_nxt = upper_r + period;
        end
        ctef_pkg::REQ_POP: begin
          if (held == '0) begin
            pend_status_nxt = ctef_pkg::STAT_EMPTY;
          end else begin
            mem_re       = 1'b1;
            pend_pop_nxt = 1'b1;
            rp_nxt       = rp_r + 1'b1;
          end
        end
        ctef_pkg::REQ_CLR_UPPER: begin
          upper_nxt = '0;
        end
        ctef_pkg::REQ_CLR_DROP: begin
          drop_nxt = '0;
        end
        ctef_pkg::REQ_FLUSH: begin
          rp_nxt = wp_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wp_r] <= ext_stamp;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_en_r    <= 1'b1;
      tbits_r       <= ctef_pkg::TBITS_MAX;
      wp_r          <= '0;
      rp_r          <= '0;
      upper_r       <= '0;
      drop_r        <= '0;
      pend_status_r <= ctef_pkg::STAT_OK;
      pend_pop_r    <= 1'b0;
    end else begin
      wp_r          <= wp_nxt;
      rp_r          <= rp_nxt;
      upper_r       <= upper_nxt;
      drop_r        <= drop_nxt;
      pend_status_r <= pend_status_nxt;
      pend_pop_r    <= pend_pop_nxt;
      if (cfg_we) begin
        unique case (ctef_pkg::cfg_idx_t'(cfg_index))
          ctef_pkg::CFG_STORE_EN:   store_en_r <= cfg_data[0];
          ctef_pkg::CFG_TIMER_BITS: tbits_r    <= cfg_data[ctef_pkg::TBITS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Output register; the pointers already hold their post-item values here.
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_status_r <= pend_status_r;
      out_stamp_r  <= pend_pop_r ? rd_data_r : '0;
      out_count_r  <= ctef_pkg::COUNT_W'(held);
      out_drop_r   <= drop_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_read_timestamp = out_stamp_r;
  assign out_entry_count    = out_count_r;
  assign out_overflow_count = out_drop_r;

endmodule
`default_nettype wire

// ===== sv/capture_timestamp_extend_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// capture_timestamp_extend_fifo
// Input-capture channel that extends raw timer values to 64-bit timestamps
// and queues them in a ring FIFO.
// ----------------------------------------------------------------------------
// Each request is accepted and acted on in S_IDLE; S_RESULT then loads the
// result into the output register once the ring memory's registered read
// port has returned the popped entry. A new request can be taken while a
// result still waits, provided that result is taken in the same cycle, but
// not before the previous request's result has been loaded. The ring holds
// up to 2**LOG_DEPTH - 1 timestamps; entry_count reports the low ten bits
// of the fill level. Configuration writes are always taken and must only be
// made while no request is in flight.
module capture_timestamp_extend_fifo #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ctef_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [ctef_pkg::VALUE_W-1:0]    in_capture_value,
  input  wire logic                            in_wrapped_flag,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ctef_pkg::STATUS_W-1:0]        out_status,
  output logic [ctef_pkg::STAMP_W-1:0]         out_read_timestamp,
  output logic [ctef_pkg::COUNT_W-1:0]         out_entry_count,
  output logic [ctef_pkg::DROP_W-1:0]          out_overflow_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ctef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctef_pkg::CFG_DATA_W-1:0] cfg_data
);

  ctef_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  ctef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ctef_datapath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_req_type        (in_req_type),
    .in_capture_value   (in_capture_value),
    .in_wrapped_flag    (in_wrapped_flag),
    .out_status         (out_status),
    .out_read_timestamp (out_read_timestamp),
    .out_entry_count    (out_entry_count),
    .out_overflow_count (out_overflow_count)
  );

endmodule
`default_nettype wire

// ===== sv/ctef_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctef_checker
// Port-level checks for the capture timestamp FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module ctef_checker #(
  parameter int unsigned LOG_DEPTH = 10
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [ctef_pkg::STATUS_W-1:0]    out_status,
  input wire logic [ctef_pkg::STAMP_W-1:0]     out_read_timestamp,
  input wire logic [ctef_pkg::COUNT_W-1:0]     out_entry_count,
  input wire logic [ctef_pkg::DROP_W-1:0]      out_overflow_count
);

  localparam logic [ctef_pkg::COUNT_W-1:0] FULL_COUNT =
    ctef_pkg::COUNT_W'((64'd1 << LOG_DEPTH) - 64'd1);

  // The block comes out of reset with no result on offer.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // Only a successful pop carries a timestamp.
  a_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ctef_pkg::STAT_OK) |-> out_read_timestamp == '0)
    else $error("non-zero timestamp on a failed request");

  // A dropped capture is only reported with the ring at its limit.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ctef_pkg::STAT_FULL) |-> out_entry_count == FULL_COUNT)
    else $error("capture dropped while the ring had room");

  // A stalled result blocks further requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while the result register is held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_read_timestamp) && $stable(out_entry_count)
      && $stable(out_overflow_count))
    else $error("result beat changed while stalled");

endmodule

bind capture_timestamp_extend_fifo ctef_checker #(
  .LOG_DEPTH (LOG_DEPTH)
) u_ctef_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_read_timestamp (out_read_timestamp),
  .out_entry_count    (out_entry_count),
  .out_overflow_count (out_overflow_count)
);
`default_nettype wire
